>>> hdl/icheck_pkg.sv
// Shared types, character constants and class codes for the infix syntax checker.
`timescale 1ns / 1ps

package icheck_pkg;

    // Character codes that the checker looks for
    localparam logic [7:0] CH_BANG   = 8'h21;  // '!'
    localparam logic [7:0] CH_PCT    = 8'h25;  // '%'
    localparam logic [7:0] CH_OPEN   = 8'h28;  // '('
    localparam logic [7:0] CH_CLOSE  = 8'h29;  // ')'
    localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CH_POINT  = 8'h2E;  // '.'
    localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
    localparam logic [7:0] CH_CARET  = 8'h5E;  // '^'

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPW         = $clog2(QUEUE_DEPTH);

    // Result status codes
    typedef enum logic [1:0] {
        ST_VALID  = 2'd0,
        ST_ARG    = 2'd1,
        ST_PAREN  = 2'd2,
        ST_NUMBER = 2'd3
    } t_status;

    // Character classes decided by the front
    typedef enum logic [2:0] {
        CL_OTHER = 3'd0,
        CL_DIGIT = 3'd1,
        CL_OPEN  = 3'd2,
        CL_CLOSE = 3'd3,
        CL_POINT = 3'd4,
        CL_SIGN  = 3'd5,
        CL_BINOP = 3'd6,
        CL_BANG  = 3'd7
    } t_cls;

    // Input transaction
    typedef struct packed {
        logic [7:0] ch;
        logic       last_char;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] bad_char;
    } t_out;

    // Classified character as it travels through the queue
    typedef struct packed {
        logic [7:0] ch;
        t_cls       cls;
        logic       last_char;
    } t_tok;

endpackage

>>> hdl/icheck_front.sv
// Front end: classifies each incoming character and hands it to the queue.
`timescale 1ns / 1ps

module icheck_front (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  icheck_pkg::t_in   i_in_data,
    output logic              o_push,
    output icheck_pkg::t_tok  o_tok,
    input  logic              i_full
);
    import icheck_pkg::*;

    t_cls w_cls;

    // Character class decoder
    always_comb begin
        w_cls = CL_OTHER;
        if (i_in_data.ch >= CH_ZERO && i_in_data.ch <= CH_NINE) begin
            w_cls = CL_DIGIT;
        end else begin
            unique case (i_in_data.ch)
                CH_OPEN:                              w_cls = CL_OPEN;
                CH_CLOSE:                             w_cls = CL_CLOSE;
                CH_POINT:                             w_cls = CL_POINT;
                CH_BANG:                              w_cls = CL_BANG;
                CH_PLUS, CH_MINUS:                    w_cls = CL_SIGN;
                CH_STAR, CH_SLASH, CH_PCT, CH_CARET:  w_cls = CL_BINOP;
                default:                              w_cls = CL_OTHER;
            endcase
        end
    end

    // Handshake into the queue
    assign o_in_ready      = !i_full;
    assign o_push          = i_in_valid && !i_full;
    assign o_tok.ch        = i_in_data.ch;
    assign o_tok.cls       = w_cls;
    assign o_tok.last_char = i_in_data.last_char;

endmodule

>>> hdl/icheck_fifo.sv
// Short queue of classified characters between front and back.
`timescale 1ns / 1ps

module icheck_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  icheck_pkg::t_tok  i_tok,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output icheck_pkg::t_tok  o_tok
);
    import icheck_pkg::*;

    t_tok           r_mem [QUEUE_DEPTH];
    logic [QPW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPW:0]   r_count,  n_count;

    // Pointer and fill tracking
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    assign o_full  = (r_count == (QPW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];

    // Checks
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPW+1)'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_push_notfull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

>>> hdl/icheck_back.sv
// Back end: judges characters with one of lookahead and one of lookbehind, holds the result.
`timescale 1ns / 1ps

module icheck_back #(
    parameter int unsigned MAX_DEPTH = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  icheck_pkg::t_tok  i_tok,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output icheck_pkg::t_out  o_out_data
);
    import icheck_pkg::*;

    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_LIMIT = DW'(MAX_DEPTH);

    // Per-expression checker state
    typedef struct packed {
        logic [DW-1:0] depth;
        logic          operand;
        logic          point;
        logic [1:0]    opcnt;
        logic          sign;
        logic          ident;
        t_status       err;
        logic [7:0]    errch;
    } t_state;

    localparam t_state STATE_CLEAR = '{depth: '0, operand: 1'b0, point: 1'b0,
                                      opcnt: 2'd0, sign: 1'b0, ident: 1'b0,
                                      err: ST_VALID, errch: 8'd0};

    // First error wins
    function automatic t_state f_latch(t_state s, t_status code, logic [7:0] c);
        t_state r;
        r = s;
        if (s.err == ST_VALID) begin
            r.err   = code;
            r.errch = c;
        end
        return r;
    endfunction

    // Judge one character given its predecessor and successor classes
    function automatic t_state f_judge(t_state s, t_cls c_cls, logic [7:0] c,
                                       t_cls b_cls, logic at_end, t_cls n_cls);
        t_state r;
        r = s;
        case (c_cls)
            CL_OPEN: begin
                if (s.depth >= DEPTH_LIMIT) begin
                    r = f_latch(r, ST_PAREN, 8'd0);
                end else begin
                    r.depth = s.depth + 1'b1;
                end
                r.operand = 1'b0;
                r.ident   = 1'b0;
                r.sign    = 1'b0;
                r.point   = 1'b0;
                r.opcnt   = 2'd0;
            end
            CL_CLOSE: begin
                if (s.depth == '0 || !s.operand) begin
                    r = f_latch(r, ST_PAREN, 8'd0);
                end else begin
                    r.depth = s.depth - 1'b1;
                end
                r.opcnt = 2'd0;
            end
            CL_POINT: begin
                if (!s.operand || s.point || at_end || n_cls != CL_DIGIT || s.ident) begin
                    r = f_latch(r, ST_NUMBER, 8'd0);
                end else begin
                    r.point = 1'b1;
                end
            end
            CL_SIGN: begin
                if (!s.sign && !(at_end || n_cls == CL_CLOSE)) begin
                    if (s.opcnt == 2'd0) begin
                        r.opcnt = 2'd1;
                    end else begin
                        r.sign = 1'b1;
                    end
                end else begin
                    r = f_latch(r, ST_ARG, c);
                end
                r.operand = 1'b0;
                r.ident   = 1'b0;
                r.point   = 1'b0;
            end
            CL_BINOP: begin
                if (s.opcnt < 2'd2) begin
                    r.opcnt = s.opcnt + 2'd1;
                end
                if (r.opcnt > 2'd1 || !s.operand || at_end || n_cls == CL_CLOSE) begin
                    r = f_latch(r, ST_ARG, c);
                end
                r.operand = 1'b0;
                r.ident   = 1'b0;
                r.point   = 1'b0;
                r.sign    = 1'b0;
            end
            CL_BANG: begin
                r.opcnt   = 2'd0;
                r.sign    = 1'b0;
                r.operand = 1'b1;
                r.point   = 1'b0;
                if (b_cls == CL_SIGN || b_cls == CL_BINOP || b_cls == CL_OPEN) begin
                    r = f_latch(r, ST_ARG, c);
                end
            end
            default: begin
                // digits and identifier characters
                r.operand = 1'b1;
                r.opcnt   = 2'd0;
                r.sign    = 1'b0;
                if (c_cls == CL_OTHER) begin
                    r.ident = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    t_state     r_st, n_st;
    logic [7:0] r_held_ch, n_held_ch;
    t_cls       r_held_cls, n_held_cls;
    logic [7:0] r_prior_ch, n_prior_ch;
    t_cls       r_prior_cls, n_prior_cls;
    logic [1:0] r_pos, n_pos;
    logic       r_out_valid;
    t_out       r_out, n_out;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_pop      = i_valid && (!i_tok.last_char || w_out_free);

    // Step: judge the held character against the new one, close out at the last
    always_comb begin
        t_state s;
        t_state f;
        s           = r_st;
        n_held_ch   = i_tok.ch;
        n_held_cls  = i_tok.cls;
        n_prior_ch  = r_held_ch;
        n_prior_cls = r_held_cls;
        if (r_pos == 2'd0) begin
            n_prior_ch  = 8'd0;
            n_prior_cls = CL_OTHER;
            if (i_tok.cls == CL_BANG) begin
                s = f_latch(s, ST_ARG, i_tok.ch);
            end
        end else begin
            // doubled leading sign
            if (r_pos == 2'd2 && r_prior_cls == CL_SIGN && r_held_cls == CL_SIGN) begin
                s = f_latch(s, ST_ARG, r_held_ch);
            end
            s = f_judge(s, r_held_cls, r_held_ch, r_prior_cls, 1'b0, i_tok.cls);
        end
        n_pos = (r_pos == 2'd3) ? r_pos : r_pos + 2'd1;

        // final character has no successor
        f = f_judge(s, n_held_cls, n_held_ch, n_prior_cls, 1'b1, CL_OTHER);
        if (f.depth != '0) begin
            f = f_latch(f, ST_PAREN, 8'd0);
        end else if (f.opcnt != 2'd0) begin
            f = f_latch(f, ST_ARG, f.sign ? n_prior_ch : n_held_ch);
        end
        n_out.status   = f.err;
        n_out.bad_char = (f.err == ST_ARG) ? f.errch : 8'd0;
        n_st           = s;
    end

    // Checker state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= STATE_CLEAR;
            r_held_ch   <= 8'd0;
            r_held_cls  <= CL_OTHER;
            r_prior_ch  <= 8'd0;
            r_prior_cls <= CL_OTHER;
            r_pos       <= 2'd0;
        end else if (o_pop) begin
            if (i_tok.last_char) begin
                r_st        <= STATE_CLEAR;
                r_held_ch   <= 8'd0;
                r_held_cls  <= CL_OTHER;
                r_prior_ch  <= 8'd0;
                r_prior_cls <= CL_OTHER;
                r_pos       <= 2'd0;
            end else begin
                r_st        <= n_st;
                r_held_ch   <= n_held_ch;
                r_held_cls  <= n_held_cls;
                r_prior_ch  <= n_prior_ch;
                r_prior_cls <= n_prior_cls;
                r_pos       <= n_pos;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= o_pop && i_tok.last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_tok.last_char) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_tok.last_char) |=> (r_pos == 2'd0 && r_st.err == ST_VALID))
        else $error("state not cleared after final character");
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.err != ST_VALID && !(o_pop && i_tok.last_char))
            |=> (r_st.err == $past(r_st.err) && r_st.errch == $past(r_st.errch)))
        else $error("latched error overwritten");
    a_depth_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.depth <= DEPTH_LIMIT)
        else $error("parenthesis depth beyond limit");
    a_badchar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_ARG) |-> (r_out.bad_char == 8'd0))
        else $error("offending character given without argument error");

endmodule

>>> hdl/infix_expression_syntax_checker.sv
// Top level of the infix expression syntax checker.
`timescale 1ns / 1ps
//
// Channel | Handshake                 | Payload                         | Direction
// --------+---------------------------+---------------------------------+----------
// in      | i_in_valid / o_in_ready   | i_in_data  (ch, last_char)      | into block
// out     | o_out_valid / i_out_ready | o_out_data (status, bad_char)   | out of block
//
// One character per cycle is taken while the four-entry queue has room.
// A character taken is first registered in the queue before it can leave it;
// a final character's result is written to the output register as it leaves the queue.
// A result waiting in the output register only holds back final characters.
// Synchronous active-low reset clears the queue, checker state and output valid.

module infix_expression_syntax_checker #(
    parameter int unsigned MAX_DEPTH = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  icheck_pkg::t_in   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output icheck_pkg::t_out  o_out_data
);
    import icheck_pkg::*;

    logic w_push, w_full, w_q_valid, w_pop;
    t_tok w_push_tok, w_q_tok;

    // Classification
    icheck_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (w_push),
        .o_tok      (w_push_tok),
        .i_full     (w_full)
    );

    // Decoupling queue
    icheck_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tok   (w_push_tok),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_tok   (w_q_tok)
    );

    // Judging and result
    icheck_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_tok       (w_q_tok),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the infix expression syntax checker.
`timescale 1ns / 1ps

module tb_top;
    import icheck_pkg::*;

    localparam int unsigned DEPTH_LIMIT  = 255;
    localparam int          CHAR_TARGET  = 700;   // characters to offer in all
    localparam int          CALM_FROM    = 600;   // no idling once this many are sent
    localparam int          HOLD_AT      = 350;   // long receiver hold-off starts here
    localparam int          HOLD_CYCLES  = 150;
    localparam int          WATCHDOG_MAX = 1000;
    localparam int          DRAIN_CYCLES = 20;

    typedef logic [7:0] char_q_t[$];

    // Predicts the verdict of each expression and checks results against it
    class verdict_board;
        t_out        verdict_q[$];
        int          mismatches;
        int unsigned max_depth;
        logic [7:0]  held_ch;
        logic [7:0]  prev_ch;
        logic [1:0]  position;
        int unsigned depth;
        bit          operand;
        bit          point;
        bit          ident;
        bit          sign_after_op;
        logic [1:0]  op_count;
        t_status     err_code;
        logic [7:0]  err_ch;

        function new(int unsigned limit);
            max_depth  = limit;
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            held_ch       = 8'h00;
            prev_ch       = 8'h00;
            position      = 2'd0;
            depth         = 0;
            operand       = 1'b0;
            point         = 1'b0;
            ident         = 1'b0;
            sign_after_op = 1'b0;
            op_count      = 2'd0;
            err_code      = ST_VALID;
            err_ch        = 8'h00;
        endfunction

        function bit is_sign(logic [7:0] c);
            return c == CH_PLUS || c == CH_MINUS;
        endfunction

        function bit is_binop(logic [7:0] c);
            return c == CH_STAR || c == CH_SLASH || c == CH_PCT || c == CH_CARET;
        endfunction

        // First error of an expression wins
        function void latch_error(t_status code, logic [7:0] c);
            if (err_code == ST_VALID) begin
                err_code = code;
                err_ch   = c;
            end
        endfunction

        // Judge one character given its predecessor and successor
        function void judge(logic [7:0] c, logic [7:0] pred, bit at_end, logic [7:0] nxt);
            if (c == CH_OPEN) begin
                if (depth >= max_depth)
                    latch_error(ST_PAREN, 8'h00);
                else
                    depth++;
                operand       = 1'b0;
                ident         = 1'b0;
                sign_after_op = 1'b0;
                point         = 1'b0;
                op_count      = 2'd0;
            end else if (c == CH_CLOSE) begin
                if (depth == 0 || !operand)
                    latch_error(ST_PAREN, 8'h00);
                else
                    depth--;
                op_count = 2'd0;
            end else if (c == CH_POINT) begin
                if (!operand || point || at_end || nxt < CH_ZERO || nxt > CH_NINE || ident)
                    latch_error(ST_NUMBER, 8'h00);
                else
                    point = 1'b1;
            end else if (is_sign(c)) begin
                if (!sign_after_op && !(at_end || nxt == CH_CLOSE)) begin
                    if (op_count == 2'd0)
                        op_count = 2'd1;
                    else
                        sign_after_op = 1'b1;
                end else begin
                    latch_error(ST_ARG, c);
                end
                operand = 1'b0;
                ident   = 1'b0;
                point   = 1'b0;
            end else if (is_binop(c)) begin
                if (op_count < 2'd2)
                    op_count++;
                if (op_count > 2'd1 || !operand || at_end || nxt == CH_CLOSE)
                    latch_error(ST_ARG, c);
                operand       = 1'b0;
                ident         = 1'b0;
                point         = 1'b0;
                sign_after_op = 1'b0;
            end else if (c == CH_BANG) begin
                op_count      = 2'd0;
                sign_after_op = 1'b0;
                operand       = 1'b1;
                point         = 1'b0;
                if (is_sign(pred) || is_binop(pred) || pred == CH_OPEN)
                    latch_error(ST_ARG, CH_BANG);
            end else begin
                // digits and identifier characters
                operand       = 1'b1;
                op_count      = 2'd0;
                sign_after_op = 1'b0;
                if (c < CH_ZERO || c > CH_NINE)
                    ident = 1'b1;
            end
        endfunction

        // Note one accepted input transaction
        function void note_char(t_in item);
            t_out verdict;
            if (position == 2'd0) begin
                prev_ch = 8'h00;
                held_ch = item.ch;
                if (item.ch == CH_BANG)
                    latch_error(ST_ARG, CH_BANG);
            end else begin
                // doubled leading sign, only seen once a third character exists
                if (position == 2'd2 && is_sign(prev_ch) && is_sign(held_ch))
                    latch_error(ST_ARG, held_ch);
                judge(held_ch, prev_ch, 1'b0, item.ch);
                prev_ch = held_ch;
                held_ch = item.ch;
            end
            if (position < 2'd3)
                position++;
            if (!item.last_char)
                return;

            judge(held_ch, prev_ch, 1'b1, 8'h00);
            if (depth != 0)
                latch_error(ST_PAREN, 8'h00);
            else if (op_count > 2'd0)
                latch_error(ST_ARG, sign_after_op ? prev_ch : held_ch);

            verdict.status   = err_code;
            verdict.bad_char = (err_code == ST_ARG) ? err_ch : 8'h00;
            verdict_q = {verdict_q, verdict};
            clear();
        endfunction

        // Compare one result transaction with the oldest prediction
        function void check_verdict(t_out got);
            t_out want;
            if (verdict_q.size() == 0) begin
                $display("%0t: expected no result actual status=%0d bad_char=%02h",
                         $time, got.status, got.bad_char);
                mismatches++;
                return;
            end
            want = verdict_q.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
            if (got.bad_char !== want.bad_char) begin
                $display("%0t: bad_char expected %02h actual %02h",
                         $time, want.bad_char, got.bad_char);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return verdict_q.size();
        endfunction
    endclass

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    logic   o_in_ready;
    t_in    i_in_data   = '0;
    logic   o_out_valid;
    logic   i_out_ready = 1'b0;
    t_out   o_out_data;

    verdict_board board = new(DEPTH_LIMIT);
    bit     idle_on     = 1'b1;
    bit     hold_req    = 1'b0;
    bit     hold_done   = 1'b0;
    int     chars_sent  = 0;
    int     quiet_cycles = 0;

    infix_expression_syntax_checker #(
        .MAX_DEPTH (DEPTH_LIMIT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one expression, a transaction per character, with random gaps
    task automatic send_chars(input char_q_t chars);
        t_in item;
        for (int i = 0; i < chars.size(); i++) begin
            if (idle_on && $urandom_range(0, 4) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            item.ch        = chars[i];
            item.last_char = (i == chars.size() - 1);
            i_in_valid <= 1'b1;
            i_in_data  <= item;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            board.note_char(item);
            chars_sent++;
        end
    endtask

    task automatic send_text(input string s);
        char_q_t chars;
        for (int i = 0; i < s.len(); i++)
            chars = {chars, 8'(s[i])};
        send_chars(chars);
    endtask

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 5))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return CH_PCT;
            default: return CH_CARET;
        endcase
    endfunction

    // Characters that the checker treats specially
    function automatic logic [7:0] pick_tricky();
        case ($urandom_range(0, 7))
            0:       return CH_BANG;
            1:       return CH_OPEN;
            2:       return CH_CLOSE;
            3:       return CH_POINT;
            4:       return CH_ZERO;
            5:       return CH_NINE;
            default: return pick_operator();
        endcase
    endfunction

    // Mostly well-formed expression with random content, sometimes broken
    function automatic char_q_t make_expression();
        char_q_t q;
        int      terms;
        int      open_cnt;
        terms    = $urandom_range(1, 5);
        open_cnt = 0;
        for (int t = 0; t < terms; t++) begin
            if (t > 0)
                q = {q, pick_operator()};
            if ($urandom_range(0, 4) == 0)
                q = {q, (($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS)};
            while (open_cnt < 3 && $urandom_range(0, 3) == 0) begin
                q = {q, CH_OPEN};
                open_cnt++;
            end
            case ($urandom_range(0, 2))
                0, 1: begin
                    repeat ($urandom_range(1, 3))
                        q = {q, 8'($urandom_range(CH_ZERO, CH_NINE))};
                    if ($urandom_range(0, 3) == 0) begin
                        q = {q, CH_POINT};
                        repeat ($urandom_range(1, 2))
                            q = {q, 8'($urandom_range(CH_ZERO, CH_NINE))};
                    end
                end
                default: begin
                    // lower-case identifier
                    repeat ($urandom_range(1, 3))
                        q = {q, 8'($urandom_range(8'h61, 8'h7A))};
                end
            endcase
            if ($urandom_range(0, 5) == 0)
                q = {q, CH_BANG};
            while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
                q = {q, CH_CLOSE};
                open_cnt--;
            end
        end
        while (open_cnt > 0) begin
            q = {q, CH_CLOSE};
            open_cnt--;
        end

        // Corrupt a share of the expressions
        case ($urandom_range(0, 11))
            7: begin
                q.delete();
                repeat ($urandom_range(1, 6))
                    q = {q, 8'($urandom_range(0, 255))};
            end
            8, 9: q[$urandom_range(0, q.size() - 1)] = pick_tricky();
            10: begin
                if (q.size() > 1)
                    q.delete($urandom_range(0, q.size() - 1));
                else
                    q = {q, pick_tricky()};
            end
            11: q.push_front(pick_tricky());
            default: ;
        endcase
        return q;
    endfunction

    // Stimulus and end of run
    initial begin
        char_q_t chars;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed expressions
        send_text("!");
        send_text("+-7");
        send_text("(2.5)");
        send_text("3*");
        send_text("1+-");
        send_text(")");
        send_text("4!/9");
        chars = {8'h00, CH_PCT, 8'hFF};
        send_chars(chars);

        // Nesting one past the depth limit
        chars = {};
        repeat (DEPTH_LIMIT + 1) chars = {chars, CH_OPEN};
        chars = {chars, CH_ZERO};
        send_chars(chars);

        // Random expressions
        while (chars_sent < CHAR_TARGET) begin
            if (chars_sent >= CALM_FROM)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            if (!hold_done && chars_sent >= HOLD_AT) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            send_chars(make_expression());
        end
        i_in_valid <= 1'b0;

        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("infix_expression_syntax_checker verification clean");
        else
            $display("infix_expression_syntax_checker verification failed");
        $finish;
    end

    // Receiver: checks result transactions and stalls at random
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                board.check_verdict(o_out_data);
            if (hold_req) begin
                // long hold-off so that the block fills and stalls its input
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 6);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("infix_expression_syntax_checker verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

>>> files.f
hdl/icheck_pkg.sv
hdl/icheck_front.sv
hdl/icheck_fifo.sv
hdl/icheck_back.sv
hdl/infix_expression_syntax_checker.sv
tb/tb_top.sv
